// ===== design/dxt_bd_pkg.sv =====
// Shared types and constants for the DXT block decoder.
package dxt_bd_pkg;

    localparam int unsigned IDX_BITS   = 2;
    localparam int unsigned NIB_BITS   = 4;
    localparam logic [3:0]  LAST_PIX   = 4'd15;
    localparam logic [9:0]  RECIP3     = 10'd683;   // 2^11 / 3, rounded up
    localparam int unsigned RECIP_SHFT = 11;
    localparam logic [7:0]  OPAQUE     = 8'hFF;
    localparam logic [7:0]  CLEAR      = 8'h00;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
    } pixel_t;

    typedef pixel_t [3:0] palette_t;

    // One decoded block as handed from the palette stage to the serialiser
    typedef struct packed {
        palette_t    pal;
        logic [31:0] idx;
        logic [63:0] nibs;
        logic        bc2;
    } blk_t;

endpackage

// ===== design/dxt_bd_palette.sv =====
// Palette stage: endpoint expansion and interpolation, one block per cycle unless held by the serialiser.
module dxt_bd_palette
    import dxt_bd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [63:0] color_word,
    input  logic [63:0] alpha_word,
    input  logic        bc2,
    input  logic        take,
    output logic        ready,
    output logic        out_valid,
    output blk_t        blk
);

    logic valid_reg;
    blk_t blk_reg;
    blk_t blk_next;

    logic [15:0] e0;
    logic [15:0] e1;
    logic        four;
    logic [7:0]  ca [3];
    logic [7:0]  cb [3];
    logic [7:0]  c2 [3];
    logic [7:0]  c3 [3];

    function automatic logic [7:0] div3(input logic [9:0] s);
        logic [19:0] p;
        p = s * RECIP3;
        return p[18:RECIP_SHFT];
    endfunction

    assign ready = !valid_reg || take;

    always_comb
    begin
        e0   = color_word[15:0];
        e1   = color_word[31:16];
        four = bc2 || (e0 > e1);
        ca[0] = {e0[15:11], e0[15:13]};
        ca[1] = {e0[10:5],  e0[10:9]};
        ca[2] = {e0[4:0],   e0[4:2]};
        cb[0] = {e1[15:11], e1[15:13]};
        cb[1] = {e1[10:5],  e1[10:9]};
        cb[2] = {e1[4:0],   e1[4:2]};
        for (int ch = 0; ch < 3; ch++)
        begin
            if (four)
            begin
                c2[ch] = div3({1'b0, ca[ch], 1'b0} + {2'b00, cb[ch]} + 10'd1);
                c3[ch] = div3({2'b00, ca[ch]} + {1'b0, cb[ch], 1'b0} + 10'd1);
            end
            else
            begin
                c2[ch] = 8'(({1'b0, ca[ch]} + {1'b0, cb[ch]}) >> 1);
                c3[ch] = CLEAR;
            end
        end
        blk_next.pal[0] = '{r: ca[0], g: ca[1], b: ca[2], a: OPAQUE};
        blk_next.pal[1] = '{r: cb[0], g: cb[1], b: cb[2], a: OPAQUE};
        blk_next.pal[2] = '{r: c2[0], g: c2[1], b: c2[2], a: OPAQUE};
        blk_next.pal[3] = '{r: c3[0], g: c3[1], b: c3[2], a: (four ? OPAQUE : CLEAR)};
        blk_next.idx    = color_word[63:32];
        blk_next.nibs   = alpha_word;
        blk_next.bc2    = bc2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (ready && in_valid)
            blk_reg <= blk_next;
    end

    assign out_valid = valid_reg;
    assign blk       = blk_reg;

endmodule

// ===== design/dxt_bd_serial.sv =====
// Serialiser: walks one block's sixteen pixels into a registered output.
module dxt_bd_serial
    import dxt_bd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       blk_valid,
    input  blk_t       blk,
    output logic       take,
    output logic       pixel_valid,
    input  logic       pixel_stall,
    output logic [7:0] red,
    output logic [7:0] green,
    output logic [7:0] blue,
    output logic [7:0] alpha,
    output logic [1:0] pixel_column,
    output logic [1:0] pixel_row,
    output logic       last_pixel
);

    logic        busy_reg;
    logic [3:0]  cnt_reg;
    palette_t    pal_reg;
    logic [31:0] idx_reg;
    logic [63:0] nibs_reg;
    logic        bc2_reg;

    logic        ov_reg;
    pixel_t      pix_reg;
    logic [3:0]  pos_reg;
    logic        last_reg;

    logic        o_load;
    logic        adv;
    pixel_t      sel_pix;
    logic [3:0]  nib;

    assign o_load = !ov_reg || !pixel_stall;
    assign adv    = busy_reg && o_load;
    assign take   = !busy_reg || (adv && (cnt_reg == LAST_PIX));

    always_comb
    begin
        sel_pix = pal_reg[idx_reg[IDX_BITS-1:0]];
        nib     = nibs_reg[NIB_BITS-1:0];
        if (bc2_reg)
            sel_pix.a = {nib, nib};   // nibble * 17
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                busy_reg <= blk_valid;
                cnt_reg  <= '0;
            end
            else if (adv)
                cnt_reg <= cnt_reg + 4'd1;
            if (o_load)
                ov_reg <= adv;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && blk_valid)
        begin
            pal_reg  <= blk.pal;
            idx_reg  <= blk.idx;
            nibs_reg <= blk.nibs;
            bc2_reg  <= blk.bc2;
        end
        else if (adv)
        begin
            idx_reg  <= idx_reg >> IDX_BITS;
            nibs_reg <= nibs_reg >> NIB_BITS;
        end
        if (adv)
        begin
            pix_reg  <= sel_pix;
            pos_reg  <= cnt_reg;
            last_reg <= (cnt_reg == LAST_PIX);
        end
    end

    assign pixel_valid  = ov_reg;
    assign red          = pix_reg.r;
    assign green        = pix_reg.g;
    assign blue         = pix_reg.b;
    assign alpha        = pix_reg.a;
    assign pixel_column = pos_reg[1:0];
    assign pixel_row    = pos_reg[3:2];
    assign last_pixel   = last_reg;

endmodule

// ===== design/dxt_block_decoder_unit.sv =====
// A block word passes the input, palette and serialiser registers on its way to the pixel outputs.
// Throughput: one pixel per cycle while pixel_stall is low; the serialiser takes the next block
// word as its last pixel advances; up to two more are held in the input and palette stages.
// Reset (rst_n, async, active low) empties every stage and sets format_mode to BC1.
// Stalls on the pixel side back up stage by stage; nothing is lost or repeated.
module dxt_block_decoder_unit
    import dxt_bd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration: format_mode, 0 = BC1, 1 = BC2
    input  logic        format_mode_we,
    input  logic        format_mode_wdata,
    // block word in
    input  logic        block_valid,
    output logic        block_stall,
    input  logic [63:0] color_block,
    input  logic [63:0] alpha_block,
    // pixel word out
    output logic        pixel_valid,
    input  logic        pixel_stall,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic [7:0]  alpha,
    output logic [1:0]  pixel_column,
    output logic [1:0]  pixel_row,
    output logic        last_pixel
);

    // Stage 1: input register, captures the block and the mode in force
    // Stage 2: palette (expand 565, interpolate by reciprocal multiply, or halve in three-colour mode)
    // Stage 3: serialiser, one pixel per cycle from the held palette while pixel_stall is low
    // Stage 4: output register inside the serialiser

    logic        mode_reg;
    logic        a_valid_reg;
    logic [63:0] a_color_reg;
    logic [63:0] a_alpha_reg;
    logic        a_bc2_reg;

    logic        pal_ready;
    logic        pal_valid;
    blk_t        pal_blk;
    logic        ser_take;
    logic        a_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= 1'b0;
        else if (format_mode_we)
            mode_reg <= format_mode_wdata;
    end

    // stage 1 frees up whenever the palette stage can take its word
    assign block_stall = a_valid_reg && !pal_ready;
    assign a_load      = block_valid && !block_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (!block_stall)
            a_valid_reg <= block_valid;
    end

    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            a_color_reg <= color_block;
            a_alpha_reg <= alpha_block;
            a_bc2_reg   <= mode_reg;
        end
    end

    dxt_bd_palette u_palette (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (a_valid_reg),
        .color_word (a_color_reg),
        .alpha_word (a_alpha_reg),
        .bc2        (a_bc2_reg),
        .take       (ser_take),
        .ready      (pal_ready),
        .out_valid  (pal_valid),
        .blk        (pal_blk)
    );

    dxt_bd_serial u_serial (
        .clk          (clk),
        .rst_n        (rst_n),
        .blk_valid    (pal_valid),
        .blk          (pal_blk),
        .take         (ser_take),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .alpha        (alpha),
        .pixel_column (pixel_column),
        .pixel_row    (pixel_row),
        .last_pixel   (last_pixel)
    );

endmodule

// ===== design/dxt_bd_checker.sv =====
// Port-level checks for the DXT block decoder, bound to the top level.
module dxt_bd_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       block_stall,
    input logic       pixel_valid,
    input logic       pixel_stall,
    input logic [7:0] red,
    input logic [7:0] green,
    input logic [7:0] blue,
    input logic [7:0] alpha,
    input logic [1:0] pixel_column,
    input logic [1:0] pixel_row,
    input logic       last_pixel
);

    // held pixel word does not move
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && pixel_stall |=>
            pixel_valid && $stable({red, green, blue, alpha, pixel_column, pixel_row, last_pixel}))
        else $error("stalled pixel word changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && last_pixel |-> pixel_column == 2'd3 && pixel_row == 2'd3)
        else $error("last flag off the final pixel");

    // a block's pixels leave back to back, in row order
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && !pixel_stall && !last_pixel |=>
            pixel_valid && {pixel_row, pixel_column} == $past({pixel_row, pixel_column}) + 4'd1)
        else $error("pixel sequence broken");

    assert property (@(posedge clk)
        !rst_n |-> !pixel_valid && !block_stall)
        else $error("pipeline not empty in reset");

endmodule

bind dxt_block_decoder_unit dxt_bd_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .block_stall  (block_stall),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .alpha        (alpha),
    .pixel_column (pixel_column),
    .pixel_row    (pixel_row),
    .last_pixel   (last_pixel)
);
